@@ rtl/utf8_to_latin1_converter_assert.svh @@
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 converter assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_LATIN1_CONVERTER_ASSERT_SVH
`define UTF8_TO_LATIN1_CONVERTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UTL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utl check failed");
`define UTL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utl check failed");
`else
`define UTL_ASSERT_IMPL(label, ante, cons)
`define UTL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/utl_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 converter package
// Payload types, burst descriptor and shared constants.
// ----------------------------------------------------------------------------
package utl_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [7:0]  QMark      = 8'h3F;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       string_last;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       run_last;
    logic       text_end;
  } out_t;

  // burst: count-1 question marks followed by the tail item
  typedef struct packed {
    logic [2:0] count;
    logic [7:0] tail_char;
    logic       tail_valid;
    logic       tail_end;
  } desc_t;

endpackage

@@ rtl/utf8_to_latin1_converter.sv @@
// Flow: a byte's burst is written into the descriptor queue on its transfer.
// Throughput: one byte per cycle while the queue has room; a byte causing k
// results takes k output transfers, absorbed by the queue (Depth bursts deep).
// Reset: asynchronous, active low; clears the open sequence, the stop flag
// and the queue; no clearing pass.
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 converter
// Front end decodes bytes into bursts, queue decouples, back end expands.
// ----------------------------------------------------------------------------
`include "utf8_to_latin1_converter_assert.svh"

module utf8_to_latin1_converter #(
  parameter int unsigned QueueDepth = utl_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  utl_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output utl_pkg::out_t  out_data_o
);

  logic           push_valid, push_ready;
  utl_pkg::desc_t push_data;
  logic           pop_valid, pop_ready;
  utl_pkg::desc_t pop_data;

  utl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  utl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  utl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (pop_valid),
    .desc_ready_o (pop_ready),
    .desc_i       (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  `UTL_ASSERT_IMPL(a_marker_ends, out_valid_o && !out_data_o.char_valid, out_data_o.text_end && out_data_o.run_last && out_data_o.char_out == 8'd0)
  `UTL_ASSERT_IMPL(a_end_is_run_last, out_valid_o && out_data_o.text_end, out_data_o.run_last)
  `UTL_ASSERT_NEXT(a_run_continues, out_valid_o && out_ready_i && !out_data_o.run_last, out_valid_o)

endmodule

@@ rtl/utl_front.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 converter front end
// Accepts bytes, tracks the open sequence, builds at most one burst per byte.
// ----------------------------------------------------------------------------
module utl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  utl_pkg::in_t    in_data_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output utl_pkg::desc_t  push_data_o
);

  logic [7:0] lead_q, lead_d;
  logic [7:0] cont_q [2];
  logic [7:0] cont_d [2];
  logic [1:0] exp_q, exp_d;
  logic [1:0] held_q, held_d;
  logic       stop_q, stop_d;

  logic [7:0]  b;
  logic        last;
  logic        do_lead;
  logic [2:0]  n;
  logic [20:0] cp;
  logic        accept;

  assign b          = in_data_i.byte_in;
  assign last       = in_data_i.string_last;
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  always_comb begin
    unique case (exp_q)
      2'd1:    cp = {10'd0, lead_q[4:0], b[5:0]};
      2'd2:    cp = {5'd0, lead_q[3:0], cont_q[0][5:0], b[5:0]};
      default: cp = {lead_q[2:0], cont_q[0][5:0], cont_q[1][5:0], b[5:0]};
    endcase
  end

  always_comb begin
    lead_d    = lead_q;
    cont_d[0] = cont_q[0];
    cont_d[1] = cont_q[1];
    exp_d     = exp_q;
    held_d    = held_q;
    stop_d    = stop_q;
    do_lead   = 1'b0;
    n         = 3'd0;
    push_data_o.tail_char  = utl_pkg::QMark;
    push_data_o.tail_valid = 1'b1;
    push_data_o.tail_end   = 1'b0;
    if (stop_q) begin
      if (last) stop_d = 1'b0;
    end else begin
      if (exp_q == 2'd0) begin
        do_lead = 1'b1;
      end else if (b[7:6] == 2'b10) begin
        if ({1'b0, held_q} + 3'd1 >= {1'b0, exp_q}) begin
          n = 3'd1;
          if (cp[20:8] == 13'd0) push_data_o.tail_char = cp[7:0];
          lead_d    = 8'd0;
          cont_d[0] = 8'd0;
          cont_d[1] = 8'd0;
          exp_d     = 2'd0;
          held_d    = 2'd0;
        end else begin
          cont_d[held_q[0]] = b;
          held_d = held_q + 2'd1;
        end
      end else begin
        n         = 3'd1 + {1'b0, held_q};
        lead_d    = 8'd0;
        cont_d[0] = 8'd0;
        cont_d[1] = 8'd0;
        exp_d     = 2'd0;
        held_d    = 2'd0;
        do_lead   = 1'b1;
      end
      if (do_lead) begin
        priority if (b == 8'd0) begin
          n = n + 3'd1;
          push_data_o.tail_char  = 8'd0;
          push_data_o.tail_valid = 1'b0;
          push_data_o.tail_end   = 1'b1;
          if (!last) stop_d = 1'b1;
        end else if (b[7] == 1'b0) begin
          n = n + 3'd1;
          push_data_o.tail_char = b;
        end else if (b[7:5] == 3'b110) begin
          lead_d = b; exp_d = 2'd1; held_d = 2'd0;
        end else if (b[7:4] == 4'b1110) begin
          lead_d = b; exp_d = 2'd2; held_d = 2'd0;
        end else if (b[7:3] == 5'b11110) begin
          lead_d = b; exp_d = 2'd3; held_d = 2'd0;
        end else begin
          n = n + 3'd1;
        end
      end
      if (last && exp_d != 2'd0) begin
        n         = n + 3'd1 + {1'b0, held_d};
        lead_d    = 8'd0;
        cont_d[0] = 8'd0;
        cont_d[1] = 8'd0;
        exp_d     = 2'd0;
        held_d    = 2'd0;
      end
      if (last) push_data_o.tail_end = 1'b1;
    end
    push_data_o.count = n;
  end

  assign push_valid_o = accept && (n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= 8'd0;
      cont_q[0] <= 8'd0;
      cont_q[1] <= 8'd0;
      exp_q     <= 2'd0;
      held_q    <= 2'd0;
      stop_q    <= 1'b0;
    end else if (accept) begin
      lead_q    <= lead_d;
      cont_q[0] <= cont_d[0];
      cont_q[1] <= cont_d[1];
      exp_q     <= exp_d;
      held_q    <= held_d;
      stop_q    <= stop_d;
    end
  end

endmodule

@@ rtl/utl_queue.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 converter burst queue
// Small FIFO of burst descriptors between front and back ends.
// ----------------------------------------------------------------------------
module utl_queue #(
  parameter int unsigned Depth = utl_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  utl_pkg::desc_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output utl_pkg::desc_t  pop_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);

  utl_pkg::desc_t mem_q [Depth];
  logic [AW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == LastPtr) ? '0 : wr_q + AW'(1);
    if (do_pop)  rd_d = (rd_q == LastPtr) ? '0 : rd_q + AW'(1);
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

@@ rtl/utl_back.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 converter back end
// Expands each burst descriptor into its run of result transfers.
// ----------------------------------------------------------------------------
module utl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            desc_valid_i,
  output logic            desc_ready_o,
  input  utl_pkg::desc_t  desc_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output utl_pkg::out_t   out_data_o
);

  logic [1:0] idx_q, idx_d;
  logic       tail;
  logic       fire;

  assign tail         = ({1'b0, idx_q} + 3'd1) == desc_i.count;
  assign out_valid_o  = desc_valid_i;
  assign fire         = out_valid_o && out_ready_i;
  assign desc_ready_o = out_ready_i && tail;

  assign out_data_o.char_out   = tail ? desc_i.tail_char : utl_pkg::QMark;
  assign out_data_o.char_valid = tail ? desc_i.tail_valid : 1'b1;
  assign out_data_o.run_last   = tail;
  assign out_data_o.text_end   = tail && desc_i.tail_end;

  always_comb begin
    idx_d = idx_q;
    if (fire) idx_d = tail ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
